// ===== rtl/aesm_pkg.sv =====
`default_nettype none
package aesm_pkg;

    localparam int NUM_ROUNDS_DEF = 10;

    localparam logic [2:0] MODE_ECB_ENC = 3'd0;
    localparam logic [2:0] MODE_ECB_DEC = 3'd1;
    localparam logic [2:0] MODE_CBC_ENC = 3'd2;
    localparam logic [2:0] MODE_CBC_DEC = 3'd3;
    localparam logic [2:0] MODE_CTR     = 3'd4;

    localparam logic [2:0] REG_KEY_HIGH = 3'd0;
    localparam logic [2:0] REG_KEY_LOW  = 3'd1;
    localparam logic [2:0] REG_IV_HIGH  = 3'd2;
    localparam logic [2:0] REG_IV_LOW   = 3'd3;
    localparam logic [2:0] REG_MODE     = 3'd4;

    localparam logic [7:0] RCON_FIRST = 8'h01;

    localparam logic [7:0] FWD_SUB [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] INV_SUB [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    function automatic logic [7:0] xt(input logic [7:0] x);
        xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Command from the sequencer to the four column lanes
    typedef struct packed {
        logic inverse;
        logic first;   // first round of a pass: key addition only
        logic last;    // no column mixing
    } lane_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/aesm_if.sv =====
`default_nettype none
interface aesm_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic        first_block;
    logic [4:0]  byte_count;
    modport source (output valid, data_high, data_low, first_block, byte_count, input ready);
    modport sink (input valid, data_high, data_low, first_block, byte_count, output ready);
endinterface

interface aesm_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic [4:0]  out_byte_count;
    modport source (output valid, out_high, out_low, out_byte_count, input ready);
    modport sink (input valid, out_high, out_low, out_byte_count, output ready);
endinterface

interface aesm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/aesm_lane.sv =====
`default_nettype none
// One state column: sub bytes on the already-shifted column, mix, add key.
// Forward order: sub, (shift done outside), mix, key. Inverse: sub, key, mix.
module aesm_lane
    import aesm_pkg::*;
(
    input  wire lane_ctl_t   ctl,
    input  wire logic [31:0] col,
    input  wire logic [31:0] rkey,
    output logic [31:0]      res
);
    logic [7:0] s [4];
    logic [7:0] k [4];
    logic [7:0] m [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] a [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            s[i] = ctl.inverse ? INV_SUB[col[31-8*i -: 8]] : FWD_SUB[col[31-8*i -: 8]];
            k[i] = rkey[31-8*i -: 8];
            a[i] = ctl.inverse ? (s[i] ^ k[i]) : s[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            x2[i] = xt(a[i]);
            x4[i] = xt(x2[i]);
            x8[i] = xt(x4[i]);
        end
        for (int r = 0; r < 4; r++)
        begin
            if (!ctl.inverse)
                m[r] = x2[r] ^ (x2[(r+1)%4] ^ a[(r+1)%4]) ^ a[(r+2)%4] ^ a[(r+3)%4];
            else
                m[r] = (x8[r] ^ x4[r] ^ x2[r])
                     ^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4])
                     ^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4])
                     ^ (x8[(r+3)%4] ^ a[(r+3)%4]);
        end
        for (int i = 0; i < 4; i++)
        begin
            if (ctl.first)
                res[31-8*i -: 8] = col[31-8*i -: 8] ^ k[i];
            else if (ctl.last)
                res[31-8*i -: 8] = ctl.inverse ? a[i] : (s[i] ^ k[i]);
            else
                res[31-8*i -: 8] = ctl.inverse ? m[i] : (m[i] ^ k[i]);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/aesm_keyexp.sv =====
`default_nettype none
// Round key expansion, one round key per cycle into a key memory.
module aesm_keyexp
    import aesm_pkg::*;
#(
    parameter int NUM_ROUNDS = NUM_ROUNDS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [127:0] key,
    input  wire logic [$clog2(NUM_ROUNDS+1)-1:0] rd_idx,
    output logic [127:0]     rd_key,
    output logic             busy
);
    localparam int RW = $clog2(NUM_ROUNDS+1);

    logic [127:0] mem [NUM_ROUNDS+1];
    logic [127:0] cur_reg;
    logic [7:0]   rc_reg;
    logic [RW-1:0] idx_reg;
    logic         busy_reg;
    logic [31:0]  t, w0, w1, w2, w3;
    logic [127:0] nxt;

    always_comb
    begin
        t = {FWD_SUB[cur_reg[23:16]], FWD_SUB[cur_reg[15:8]],
             FWD_SUB[cur_reg[7:0]], FWD_SUB[cur_reg[31:24]]} ^ {rc_reg, 24'h0};
        w0 = cur_reg[127:96] ^ t;
        w1 = cur_reg[95:64] ^ w0;
        w2 = cur_reg[63:32] ^ w1;
        w3 = cur_reg[31:0] ^ w2;
        nxt = {w0, w1, w2, w3};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= RW'(1);
        end
        else if (busy_reg)
        begin
            if (idx_reg == RW'(NUM_ROUNDS))
                busy_reg <= 1'b0;
            idx_reg <= idx_reg + RW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cur_reg <= key;
            rc_reg  <= RCON_FIRST;
            mem[0]  <= key;
        end
        else if (busy_reg)
        begin
            cur_reg      <= nxt;
            rc_reg       <= xt(rc_reg);
            mem[idx_reg] <= nxt;
        end
        rd_key <= mem[rd_idx];
    end

    assign busy = busy_reg | start;
endmodule
`default_nettype wire

// ===== rtl/aes128_block_cipher_modes.sv =====
`default_nettype none
// Channel | dir | handshake    | payload
// cfg     | in  | valid/ready  | index, data
// in      | in  | valid/ready  | data_high, data_low, first_block, byte_count
// out     | out | valid/ready  | out_high, out_low, out_byte_count
// A request is taken in the idle state: the state is loaded, then key addition plus ten
// rounds run at one per cycle through four column lanes, then the result is merged into
// the result register. The next request is taken only once the engine is back in idle.
// A first block runs the key expansion first. A result still waiting in the output
// register holds the engine in its merge state. Reset clears control, mode, key, IV, chain.
module aes128_block_cipher_modes
    import aesm_pkg::*;
#(
    parameter int NUM_ROUNDS = NUM_ROUNDS_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    aesm_cfg_if.sink    cfg,
    aesm_in_if.sink     in_ch,
    aesm_out_if.source  out_ch
);
    localparam int RW = $clog2(NUM_ROUNDS+1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_KEYS = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t        state_reg;
    logic [127:0]  key_reg, iv_reg, chain_reg, data_reg, st_reg;
    logic [2:0]    mode_reg;
    logic [4:0]    cnt_reg;
    logic [RW:0]   step_reg;
    logic [RW-1:0] rd_idx;
    logic [127:0]  rkey, shifted, rnd;
    logic          ke_busy, ke_start, inv;
    logic          out_valid_reg;
    logic          out_load;
    logic [127:0]  out_reg;
    logic [4:0]    out_cnt_reg;
    lane_ctl_t     ctl;
    logic [127:0]  src, fin, res;
    logic [4:0]    cnt_eff;

    assign cfg.ready = 1'b1;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign inv = (mode_reg == MODE_ECB_DEC) || (mode_reg == MODE_CBC_DEC);
    assign ke_start = in_ch.valid && in_ch.ready && in_ch.first_block;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);

    // step 0: key read issued; step s (1..NUM_ROUNDS+1) applies round s-1
    always_comb
    begin
        if (step_reg > (RW+1)'(NUM_ROUNDS))
            rd_idx = '0;
        else if (inv)
            rd_idx = RW'(NUM_ROUNDS) - step_reg[RW-1:0];
        else
            rd_idx = step_reg[RW-1:0];
    end

    aesm_keyexp #(.NUM_ROUNDS(NUM_ROUNDS)) u_keyexp (
        .clk(clk), .rst_n(rst_n), .start(ke_start), .key(key_reg),
        .rd_idx(rd_idx), .rd_key(rkey), .busy(ke_busy)
    );

    // byte b at bits 127-8b, state byte row r col c is b = r + 4c
    always_comb
    begin
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                shifted[127-8*(r+4*c) -: 8] = inv ? st_reg[127-8*(r+4*((c-r+4)%4)) -: 8]
                                                  : st_reg[127-8*(r+4*((c+r)%4)) -: 8];
        ctl.inverse = inv;
        ctl.first   = (step_reg == (RW+1)'(1));
        ctl.last    = (step_reg == (RW+1)'(NUM_ROUNDS+1));
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        aesm_lane u_lane (
            .ctl(ctl),
            .col(ctl.first ? st_reg[127-32*g -: 32] : shifted[127-32*g -: 32]),
            .rkey(rkey[127-32*g -: 32]),
            .res(rnd[127-32*g -: 32])
        );
    end

    // merge stage: chaining and byte masking
    always_comb
    begin
        case (mode_reg)
            MODE_CBC_ENC: src = data_reg ^ chain_reg;
            MODE_CTR:     src = chain_reg;
            default:      src = data_reg;
        endcase
        cnt_eff = 5'd16;
        if (mode_reg == MODE_CTR && cnt_reg >= 5'd1 && cnt_reg <= 5'd16)
            cnt_eff = cnt_reg;
        case (mode_reg)
            MODE_CBC_DEC: fin = st_reg ^ chain_reg;
            MODE_CTR:     fin = st_reg ^ data_reg;
            default:      fin = st_reg;
        endcase
        for (int b = 0; b < 16; b++)
            res[127-8*b -: 8] = (5'(b) < cnt_eff) ? fin[127-8*b -: 8] : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_reg       <= '0;
            iv_reg        <= '0;
            mode_reg      <= MODE_ECB_ENC;
            chain_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_KEY_HIGH: key_reg[127:64] <= cfg.data;
                    REG_KEY_LOW:  key_reg[63:0]   <= cfg.data;
                    REG_IV_HIGH:  iv_reg[127:64]  <= cfg.data;
                    REG_IV_LOW:   iv_reg[63:0]    <= cfg.data;
                    REG_MODE:     mode_reg <= (cfg.data[2:0] > MODE_CTR) ? MODE_ECB_ENC
                                                                         : cfg.data[2:0];
                    default: ;
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (in_ch.valid && in_ch.ready)
                    begin
                        if (in_ch.first_block)
                            chain_reg <= iv_reg;
                        step_reg  <= '0;
                        state_reg <= in_ch.first_block ? ST_KEYS : ST_RUN;
                    end
                ST_KEYS:
                    if (!ke_busy)
                        state_reg <= ST_RUN;
                ST_RUN:
                begin
                    if (step_reg == '0)
                        st_reg <= src;
                    else
                        st_reg <= rnd;
                    step_reg <= step_reg + (RW+1)'(1);
                    if (ctl.last)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                    if (out_load)
                    begin
                        out_reg     <= res;
                        out_cnt_reg <= cnt_eff;
                        unique case (mode_reg)
                            MODE_CBC_ENC: chain_reg <= st_reg;
                            MODE_CBC_DEC: chain_reg <= data_reg;
                            MODE_CTR:     chain_reg[31:0] <= chain_reg[31:0] + 32'd1;
                            default: ;
                        endcase
                        state_reg <= ST_IDLE;
                    end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // rnd on the last step lands in st_reg; the merge stage reads st_reg in DONE
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            data_reg <= {in_ch.data_high, in_ch.data_low};
            cnt_reg  <= in_ch.byte_count;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.out_high       = out_reg[127:64];
    assign out_ch.out_low        = out_reg[63:0];
    assign out_ch.out_byte_count = out_cnt_reg;
endmodule
`default_nettype wire

// ===== test/aes128_block_cipher_modes_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module aes128_block_cipher_modes_tb;
    import aesm_pkg::*;

    // modes five to seven behave as ECB encrypt
    localparam logic [2:0] MODE_ALIAS_ENC = 3'd7;
    localparam int         SETTLE_CYCLES  = 30;
    localparam int         RANDOM_BLOCKS  = 1950;
    localparam int         HOLDOFF_CYCLES = 400;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [63:0] a;
        logic [63:0] b;
        bit          first;
        logic [4:0]  cnt;
        bit          typed;
        logic [63:0] exp_high;
        logic [63:0] exp_low;
        logic [4:0]  exp_cnt;
    } stim_row_t;

    typedef struct {
        bit          typed;
        logic [63:0] out_high;
        logic [63:0] out_low;
        logic [4:0]  out_cnt;
    } cipher_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    aesm_cfg_if cfg_bus ();
    aesm_in_if  in_bus ();
    aesm_out_if out_bus ();

    aes128_block_cipher_modes dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .in_ch  (in_bus),
        .out_ch (out_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow state of the cipher
    logic [63:0]    sh_key_high, sh_key_low, sh_iv_high, sh_iv_low;
    logic [2:0]     sh_mode;
    logic [127:0]   sh_round_key [0:10];
    logic [127:0]   sh_chain;

    cipher_result_t typed_pending [$];
    cipher_result_t blocks_due [$];

    int errors = 0;
    int blocks_sent = 0;
    int blocks_checked = 0;
    int settings_used = 0;
    int ctr_partial = 0;
    int burst_left = 0;
    int holdoff_req = 0;
    int holdoff_done = 0;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= a;
            a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
        end
        return acc;
    endfunction

    function automatic logic [127:0] sub_all(input logic [127:0] s, input bit inv);
        for (int i = 0; i < 16; i++)
            s[127-8*i -: 8] = inv ? INV_SUB[s[127-8*i -: 8]] : FWD_SUB[s[127-8*i -: 8]];
        return s;
    endfunction

    // byte index is row + 4*column
    function automatic logic [127:0] rotate_rows(input logic [127:0] s, input bit inv);
        logic [127:0] n;
        int src;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
            begin
                src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
                n[127-8*(r+4*c) -: 8] = s[127-8*(r+4*src) -: 8];
            end
        return n;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input bit inv);
        logic [7:0] fm [4];
        logic [7:0] im [4];
        logic [7:0] v;
        logic [127:0] n;
        fm = '{8'd2, 8'd3, 8'd1, 8'd1};
        im = '{8'd14, 8'd11, 8'd13, 8'd9};
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                v = 8'h00;
                for (int k = 0; k < 4; k++)
                    v ^= gf_mul(s[127-8*(4*c+k) -: 8], inv ? im[(k-r+4)&3] : fm[(k-r+4)&3]);
                n[127-8*(4*c+r) -: 8] = v;
            end
        return n;
    endfunction

    function automatic void expand_round_keys();
        logic [31:0] w [0:43];
        logic [31:0] t;
        logic [7:0] rc;
        rc = 8'h01;
        {w[0], w[1], w[2], w[3]} = {sh_key_high, sh_key_low};
        for (int i = 4; i < 44; i++)
        begin
            t = w[i-1];
            if (i % 4 == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {FWD_SUB[t[31:24]], FWD_SUB[t[23:16]], FWD_SUB[t[15:8]], FWD_SUB[t[7:0]]};
                t[31:24] ^= rc;
                rc = gf_mul(rc, 8'h02);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r <= 10; r++)
            sh_round_key[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endfunction

    function automatic logic [127:0] aes_encrypt(input logic [127:0] s);
        s ^= sh_round_key[0];
        for (int r = 1; r <= 10; r++)
        begin
            s = rotate_rows(sub_all(s, 1'b0), 1'b0);
            if (r != 10)
                s = mix_columns(s, 1'b0);
            s ^= sh_round_key[r];
        end
        return s;
    endfunction

    function automatic logic [127:0] aes_decrypt(input logic [127:0] s);
        s ^= sh_round_key[10];
        for (int r = 9; r >= 0; r--)
        begin
            s = sub_all(rotate_rows(s, 1'b1), 1'b1);
            s ^= sh_round_key[r];
            if (r != 0)
                s = mix_columns(s, 1'b1);
        end
        return s;
    endfunction

    function automatic cipher_result_t cipher_block(input logic [63:0] dh, input logic [63:0] dl,
                                                   input logic first, input logic [4:0] n);
        cipher_result_t res;
        logic [127:0] d, o, ks;
        int cnt;
        cnt = 16;
        if (first)
        begin
            expand_round_keys();
            sh_chain = {sh_iv_high, sh_iv_low};
        end
        d = {dh, dl};
        case (sh_mode)
            MODE_ECB_DEC: o = aes_decrypt(d);
            MODE_CBC_ENC:
            begin
                o = aes_encrypt(d ^ sh_chain);
                sh_chain = o;
            end
            MODE_CBC_DEC:
            begin
                o = aes_decrypt(d) ^ sh_chain;
                sh_chain = d;
            end
            MODE_CTR:
            begin
                if (n >= 1 && n <= 16)
                    cnt = n;
                ks = aes_encrypt(sh_chain);
                o = d ^ ks;
                for (int i = cnt; i < 16; i++)
                    o[127-8*i -: 8] = 8'h00;
                sh_chain[31:0] = sh_chain[31:0] + 32'd1;
            end
            default: o = aes_encrypt(d);
        endcase
        res.typed = 1'b0;
        res.out_high = o[127:64];
        res.out_low = o[63:0];
        res.out_cnt = 5'(cnt);
        return res;
    endfunction

    // accepted requests and register writes
    always @(posedge clk)
    begin
        cipher_result_t r, t;
        if (rst_n && cfg_bus.valid && cfg_bus.ready)
        begin
            case (cfg_bus.index)
                REG_KEY_HIGH: sh_key_high = cfg_bus.data;
                REG_KEY_LOW:  sh_key_low = cfg_bus.data;
                REG_IV_HIGH:  sh_iv_high = cfg_bus.data;
                REG_IV_LOW:   sh_iv_low = cfg_bus.data;
                REG_MODE:     sh_mode = cfg_bus.data[2:0];
                default: ;
            endcase
        end
        if (rst_n && in_bus.valid && in_bus.ready)
        begin
            r = cipher_block(in_bus.data_high, in_bus.data_low, in_bus.first_block,
                             in_bus.byte_count);
            if (sh_mode == MODE_CTR && r.out_cnt != 5'd16)
                ctr_partial++;
            t = typed_pending.pop_front();
            blocks_due.push_back(t.typed ? t : r);
        end
    end

    always @(posedge clk)
    begin
        cipher_result_t e;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (blocks_due.size() == 0)
            begin
                $error("result with nothing outstanding: %h %h", out_bus.out_high, out_bus.out_low);
                errors++;
            end
            else
            begin
                e = blocks_due.pop_front();
                blocks_checked++;
                if (out_bus.out_high !== e.out_high)
                begin
                    $error("out_high: expected %h, got %h", e.out_high, out_bus.out_high);
                    errors++;
                end
                if (out_bus.out_low !== e.out_low)
                begin
                    $error("out_low: expected %h, got %h", e.out_low, out_bus.out_low);
                    errors++;
                end
                if (out_bus.out_byte_count !== e.out_cnt)
                begin
                    $error("out_byte_count: expected %0d, got %0d", e.out_cnt,
                           out_bus.out_byte_count);
                    errors++;
                end
            end
        end
    end

    // receiver: stall pattern rotates through three patterns, long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        int hold, tick;
        if (!rst_n)
        begin
            out_bus.ready <= 1'b0;
            hold = 0;
            tick = 0;
        end
        else
        begin
            tick++;
            if (holdoff_done != holdoff_req)
            begin
                holdoff_done = holdoff_req;
                hold = HOLDOFF_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                out_bus.ready <= 1'b0;
            end
            else
                case ((tick >> 8) % 3)
                    0: out_bus.ready <= 1'b1;
                    1: out_bus.ready <= ($urandom_range(0, 3) != 0);
                    default: out_bus.ready <= ($urandom_range(0, 1) != 0);
                endcase
        end
    end

    task automatic send_block(input logic [63:0] dh, input logic [63:0] dl, input logic first,
                              input logic [4:0] n, input cipher_result_t typed_exp);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0)
            begin
                in_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
        burst_left--;
        typed_pending.push_back(typed_exp);
        in_bus.valid <= 1'b1;
        in_bus.data_high <= dh;
        in_bus.data_low <= dl;
        in_bus.first_block <= first;
        in_bus.byte_count <= n;
        do
            @(posedge clk);
        while (!in_bus.ready);
        blocks_sent++;
    endtask

    task automatic drain();
        in_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (blocks_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 64'h0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    initial
    begin
        stim_row_t table_rows [$];
        stim_row_t row;
        cipher_result_t none, t;
        logic [2:0] m;
        int msg_len;
        logic [4:0] n;

        none = '{1'b0, 64'h0, 64'h0, 5'd0};
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_KEY_HIGH;
        cfg_bus.data = '0;
        in_bus.valid = 1'b0;
        in_bus.data_high = '0;
        in_bus.data_low = '0;
        in_bus.first_block = 1'b0;
        in_bus.byte_count = 5'd16;
        sh_key_high = '0;
        sh_key_low = '0;
        sh_iv_high = '0;
        sh_iv_low = '0;
        sh_mode = MODE_ECB_ENC;
        sh_chain = '0;
        for (int r = 0; r <= 10; r++)
            sh_round_key[r] = '0;

        // directed part: standard vector in every direction, then chaining and counter cases
        table_rows = '{
            '{1, REG_KEY_HIGH, 64'h0001020304050607, 0, 0, 0, 0, 0, 0, 0},
            '{1, REG_KEY_LOW, 64'h08090a0b0c0d0e0f, 0, 0, 0, 0, 0, 0, 0},
            '{1, REG_MODE, MODE_ECB_ENC, 0, 0, 0, 0, 0, 0, 0},
            '{0, 0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1, 16, 1,
              64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 16},
            '{0, 0, 64'h0, 64'h0, 0, 0, 0, 0, 0, 0},
            '{0, 0, '1, '1, 0, 31, 0, 0, 0, 0},
            '{1, REG_MODE, MODE_ECB_DEC, 0, 0, 0, 0, 0, 0, 0},
            '{0, 0, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 0, 7, 1,
              64'h0011223344556677, 64'h8899aabbccddeeff, 16},
            '{1, REG_MODE, MODE_ALIAS_ENC, 0, 0, 0, 0, 0, 0, 0},
            '{0, 0, 64'h0011223344556677, 64'h8899aabbccddeeff, 0, 16, 1,
              64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 16},
            '{1, REG_IV_HIGH, 64'hf0e1d2c3b4a59687, 0, 0, 0, 0, 0, 0, 0},
            '{1, REG_IV_LOW, 64'h78695a4bfffffffe, 0, 0, 0, 0, 0, 0, 0},
            '{1, REG_MODE, MODE_CBC_ENC, 0, 0, 0, 0, 0, 0, 0},
            '{0, 0, 64'h0123456789abcdef, 64'hfedcba9876543210, 1, 16, 0, 0, 0, 0},
            '{0, 0, '1, 64'h0, 0, 16, 0, 0, 0, 0},
            '{0, 0, 64'h0, '1, 0, 16, 0, 0, 0, 0},
            '{1, REG_MODE, MODE_CBC_DEC, 0, 0, 0, 0, 0, 0, 0},
            '{0, 0, 64'h0123456789abcdef, 64'hfedcba9876543210, 1, 16, 0, 0, 0, 0},
            '{0, 0, 64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 0, 16, 0, 0, 0, 0},
            // counter low word wraps after two blocks
            '{1, REG_MODE, MODE_CTR, 0, 0, 0, 0, 0, 0, 0},
            '{0, 0, '1, '1, 1, 16, 0, 0, 0, 0},
            '{0, 0, '1, '1, 0, 0, 0, 0, 0, 0},
            '{0, 0, 64'h0, 64'h0, 0, 20, 0, 0, 0, 0},
            '{0, 0, '1, '1, 0, 1, 0, 0, 0, 0},
            '{0, 0, '1, '1, 0, 15, 0, 0, 0, 0},
            // new key is not used until the next first block
            '{1, REG_KEY_HIGH, '1, 0, 0, 0, 0, 0, 0, 0},
            '{0, 0, 64'h1111111111111111, 64'h2222222222222222, 0, 16, 0, 0, 0, 0},
            '{0, 0, 64'h1111111111111111, 64'h2222222222222222, 1, 8, 0, 0, 0, 0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
        begin
            row = table_rows[i];
            if (row.is_cfg)
            begin
                drain();
                write_reg(row.idx, row.a);
            end
            else
            begin
                t = '{row.typed, row.exp_high, row.exp_low, row.exp_cnt};
                send_block(row.a, row.b, row.first, row.cnt, t);
            end
        end

        // random phases: new settings, then a few messages, most opening with a first block
        for (int phase = 0; blocks_sent < RANDOM_BLOCKS + 20; phase++)
        begin
            drain();
            settings_used++;
            if ($urandom_range(0, 3) != 0)
                m = 3'($urandom_range(MODE_ECB_ENC, MODE_CTR));
            else
                m = 3'($urandom_range(0, 7));
            write_reg(REG_KEY_HIGH, pick_word());
            write_reg(REG_KEY_LOW, pick_word());
            write_reg(REG_IV_HIGH, pick_word());
            write_reg(REG_IV_LOW, ($urandom_range(0, 3) == 0)
                      ? {$urandom(), 32'hffffffff - $urandom_range(0, 3)} : pick_word());
            write_reg(REG_MODE, m);
            if (phase == 8)
                holdoff_req++;
            repeat ($urandom_range(1, 4))
            begin
                msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
                for (int k = 0; k < msg_len; k++)
                begin
                    if (m == MODE_CTR && k == msg_len - 1)
                        n = 5'($urandom_range(1, 16));
                    else if ($urandom_range(0, 4) == 0)
                        n = 5'($urandom_range(0, 31));
                    else
                        n = 5'd16;
                    // now and then a message carries on the previous chain
                    send_block(rand64(), pick_word(), (k == 0) && ($urandom_range(0, 9) != 0),
                               n, none);
                end
            end
        end

        in_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (blocks_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d blocks checked across %0d random settings, %0d short counter blocks",
                 blocks_checked, settings_used, ctr_partial);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
